[hdl/abd3_pkg.sv]
// Shared package of the 3D anchor box delta decoder.
// Holds widths, fixed-point constants, register codes and the exp table builder.
// Depends on nothing.
`default_nettype none

package abd3_pkg;

  // Field and datapath widths.
  localparam int unsigned ANCHOR_W       = 14;
  localparam int unsigned DELTA_W        = 16;
  localparam int unsigned BOX_W          = 16;
  localparam int unsigned SIZE_W         = 13;
  localparam int unsigned GAIN_W         = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  // Fixed-point formats.
  localparam int unsigned COORD_WIDTH     = 16;
  localparam int unsigned DELTA_FRAC_BITS = 12;
  localparam int unsigned TABLE_FRAC_BITS = 30;
  localparam int unsigned GAIN_FRAC_BITS  = 12;
  localparam int unsigned OUT_FRAC_BITS   = 4;
  localparam int unsigned TAYLOR_TERMS    = 24;
  localparam int unsigned EXP_SHIFT       = DELTA_FRAC_BITS + TABLE_FRAC_BITS;
  localparam int unsigned HALF_SHIFT_BASE =
    TABLE_FRAC_BITS + GAIN_FRAC_BITS + 1 - OUT_FRAC_BITS;

  // log2(e) and ln(2) in Q.30.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;

  // Default exp table depth.
  localparam int unsigned ABD3_EXP_TABLE_DEPTH = 256;

  // Register reset values.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
  localparam logic [BOX_W-1:0]  MIN_RESET  = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  // Register codes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X   = 3'd0,
    REG_SIZE_Y   = 3'd1,
    REG_SIZE_Z   = 3'd2,
    REG_MIN_SIZE = 3'd3,
    REG_GAIN     = 3'd4
  } abd3_reg_e;

  // Load enables of the four datapath stages in each axis.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } abd3_stage_en_t;

  // Integer Taylor series of exp(a), a in Q.30; used at elaboration only.
  function automatic logic [63:0] exp_taylor(input logic [63:0] a);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << TABLE_FRAC_BITS;
    sum  = term;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * a) >> TABLE_FRAC_BITS) / 64'(k);
      sum  = sum + term;
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

[hdl/abd3_exp_rom.sv]
// Constant table of 2^(i/depth) in Q1.30 for the exp unit.
// Depends on abd3_pkg.
`default_nettype none

module abd3_exp_rom
  import abd3_pkg::*;
#(
  parameter int unsigned EXP_TABLE_DEPTH = ABD3_EXP_TABLE_DEPTH,
  localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH)
) (
  input  wire logic [IDX_W-1:0] idx_i,
  output logic [30:0]           mant_o
);

  logic [30:0] tab_w [EXP_TABLE_DEPTH];

  // Each entry is fixed at elaboration from the Taylor series.
  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_tab
    localparam logic [63:0] Arg = (64'(gi) * LN2_Q30) / 64'(EXP_TABLE_DEPTH);
    localparam logic [63:0] Val = exp_taylor(Arg);
    assign tab_w[gi] = Val[30:0];
  end

  assign mant_o = tab_w[idx_i];

endmodule

`default_nettype wire

[hdl/abd3_axis.sv]
// Four-stage datapath for one axis: extent, centre, exp, size product and clip.
// Depends on abd3_pkg and abd3_exp_rom.
`default_nettype none

module abd3_axis
  import abd3_pkg::*;
#(
  parameter int unsigned EXP_TABLE_DEPTH = ABD3_EXP_TABLE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire abd3_stage_en_t             en_i,
  input  wire logic signed [ANCHOR_W-1:0] anchor_lo_i,
  input  wire logic signed [ANCHOR_W-1:0] anchor_hi_i,
  input  wire logic signed [DELTA_W-1:0]  shift_i,
  input  wire logic signed [DELTA_W-1:0]  log_scale_i,
  input  wire logic [GAIN_W-1:0]          gain_i,
  input  wire logic [SIZE_W-1:0]          size_i,
  output logic [BOX_W-1:0]                box_lo_o,
  output logic [BOX_W-1:0]                box_hi_o,
  output logic                            inside_o
);

  localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned Y_W   = 47;
  localparam int unsigned V_W   = 38;

  // Stage 1: extent, base centre and the three products.
  logic signed [15:0] ext_w;
  logic [15:0]        mag16_w;
  logic [15:0]        xabs_w;
  logic signed [19:0] ctrb_d, ctrb_q;
  logic signed [31:0] de_d, de_q;
  logic [Y_W-1:0]     y_d, y_q;
  logic [30:0]        mg_d, mg_q;
  logic               eneg_d, eneg_q;
  logic               xneg_d, xneg_q;
  logic               ins_d, ins1_q;

  always_comb begin
    ext_w   = {{2{anchor_hi_i[ANCHOR_W-1]}}, anchor_hi_i}
            - {{2{anchor_lo_i[ANCHOR_W-1]}}, anchor_lo_i} + 16'sd1;
    mag16_w = ext_w[15] ? (~ext_w + 16'd1) : ext_w;
    xabs_w  = log_scale_i[DELTA_W-1] ? (~log_scale_i + 16'd1) : log_scale_i;
    ctrb_d  = {{2{anchor_lo_i[ANCHOR_W-1]}}, anchor_lo_i, 4'b0}
            + {{1{ext_w[15]}}, ext_w, 3'b0};
    de_d    = shift_i * ext_w;
    mg_d    = 31'(mag16_w[14:0]) * 31'(gain_i);
    y_d     = 47'(xabs_w) * 47'(LOG2E_Q30);
    eneg_d  = ext_w[15];
    xneg_d  = log_scale_i[DELTA_W-1];
    ins_d   = !anchor_lo_i[ANCHOR_W-1]
            && (anchor_hi_i < $signed({1'b0, size_i}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      ctrb_q <= ctrb_d;
      de_q   <= de_d;
      y_q    <= y_d;
      mg_q   <= mg_d;
      eneg_q <= eneg_d;
      xneg_q <= xneg_d;
      ins1_q <= ins_d;
    end
  end

  // Stage 2: split the exponent, read the table, finish the centre.
  logic [EXP_SHIFT-1:0]        rm_w;
  logic [EXP_SHIFT-1:0]        r_w;
  logic [EXP_SHIFT+IDX_W:0]    ridx_w;
  logic [IDX_W-1:0]            idx_w;
  logic [30:0]                 mant_w;
  logic signed [31:0]          rnd_w;
  logic signed [5:0]           n_d, n2_q, n3_q;
  logic signed [23:0]          ctr_d, ctr2_q, ctr3_q;
  logic [30:0]                 t_q;
  logic [30:0]                 mg2_q;
  logic                        eneg2_q, eneg3_q;
  logic                        ins2_q, ins3_q;

  always_comb begin
    rm_w = y_q[EXP_SHIFT-1:0];
    if (xneg_q) begin
      n_d = -$signed({1'b0, y_q[Y_W-1:EXP_SHIFT]}) - ((rm_w != '0) ? 6'sd1 : 6'sd0);
      r_w = '0 - rm_w;
    end else begin
      n_d = $signed({1'b0, y_q[Y_W-1:EXP_SHIFT]});
      r_w = rm_w;
    end
    ridx_w = (EXP_SHIFT+IDX_W+1)'(r_w) * (EXP_SHIFT+IDX_W+1)'(EXP_TABLE_DEPTH);
    idx_w  = ridx_w[EXP_SHIFT +: IDX_W];
    rnd_w  = de_q + 32'sd128;
    ctr_d  = {{4{ctrb_q[19]}}, ctrb_q} + rnd_w[31:8];
  end

  abd3_exp_rom #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_rom (
    .idx_i (idx_w),
    .mant_o(mant_w)
  );

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      t_q     <= mant_w;
      n2_q    <= n_d;
      ctr2_q  <= ctr_d;
      mg2_q   <= mg_q;
      eneg2_q <= eneg_q;
      ins2_q  <= ins1_q;
    end
  end

  // Stage 3: mantissa times extent times gain.
  logic [61:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      p_q     <= 62'(t_q) * 62'(mg2_q);
      n3_q    <= n2_q;
      ctr3_q  <= ctr2_q;
      eneg3_q <= eneg2_q;
      ins3_q  <= ins2_q;
    end
  end

  // Stage 4: round the half size, form the corners and clip them.
  logic signed [6:0]  s7_w;
  logic [5:0]         s_w;
  logic [62:0]        sum_w;
  logic [62:0]        hs_w;
  logic signed [V_W-1:0] half_w, ctrx_w, lo_v_w, hi_v_w;
  logic [16:0]        lim17_w;
  logic signed [V_W-1:0] lim_w;
  logic [BOX_W-1:0]   lo_c_d, hi_c_d, lo_c_q, hi_c_q;
  logic               ins4_q;

  always_comb begin
    s7_w    = 7'(HALF_SHIFT_BASE) - {n3_q[5], n3_q};
    s_w     = s7_w[5:0];
    sum_w   = {1'b0, p_q} + (63'd1 << (s_w - 6'd1));
    hs_w    = sum_w >> s_w;
    half_w  = eneg3_q ? -$signed({3'b0, hs_w[34:0]}) : $signed({3'b0, hs_w[34:0]});
    ctrx_w  = {{(V_W-24){ctr3_q[23]}}, ctr3_q};
    lo_v_w  = ctrx_w - half_w;
    hi_v_w  = ctrx_w + half_w;
    lim17_w = (size_i == '0) ? 17'd0 : {size_i - 13'd1, 4'b0};
    if (lim17_w > 17'((1 << COORD_WIDTH) - 1)) begin
      lim17_w = 17'((1 << COORD_WIDTH) - 1);
    end
    lim_w   = $signed({{(V_W-17){1'b0}}, lim17_w});
    if (lo_v_w > lim_w) begin
      lo_c_d = lim17_w[BOX_W-1:0];
    end else if (lo_v_w < 0) begin
      lo_c_d = '0;
    end else begin
      lo_c_d = lo_v_w[BOX_W-1:0];
    end
    if (hi_v_w > lim_w) begin
      hi_c_d = lim17_w[BOX_W-1:0];
    end else if (hi_v_w < 0) begin
      hi_c_d = '0;
    end else begin
      hi_c_d = hi_v_w[BOX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      lo_c_q <= lo_c_d;
      hi_c_q <= hi_c_d;
      ins4_q <= ins3_q;
    end
  end

  assign box_lo_o = lo_c_q;
  assign box_hi_o = hi_c_q;
  assign inside_o = ins4_q;

endmodule

`default_nettype wire

[hdl/anchor_box_delta_decoder_3d_top.sv]
// Top level of the 3D anchor box delta decoder: registers, valid pipeline, keep stage.
// Depends on abd3_pkg and abd3_axis.
//
//   Channel | Direction | Handshake             | Beat
//   in      | sink      | in_valid_i/in_stall_o | anchor corners and six deltas
//   out     | source    | out_valid_o/out_stall_i | clipped box corners and keep
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | register index and data
//
// Five register stages; one beat is taken every cycle unless the output stall
// backs up into the first stage. The depth is set by the exp table read and the
// 31 by 31 bit size product, each in a stage of its own.
// Reset clears the valid bits and loads the register defaults. A stage holds only
// while it is full and the stage after it cannot take its beat, so bubbles close up.
`default_nettype none

module anchor_box_delta_decoder_3d_top
  import abd3_pkg::*;
#(
  parameter int unsigned EXP_TABLE_DEPTH = ABD3_EXP_TABLE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [ANCHOR_W-1:0] anchor_x_lo_i,
  input  wire logic signed [ANCHOR_W-1:0] anchor_y_lo_i,
  input  wire logic signed [ANCHOR_W-1:0] anchor_z_lo_i,
  input  wire logic signed [ANCHOR_W-1:0] anchor_x_hi_i,
  input  wire logic signed [ANCHOR_W-1:0] anchor_y_hi_i,
  input  wire logic signed [ANCHOR_W-1:0] anchor_z_hi_i,
  input  wire logic signed [DELTA_W-1:0]  shift_x_i,
  input  wire logic signed [DELTA_W-1:0]  shift_y_i,
  input  wire logic signed [DELTA_W-1:0]  shift_z_i,
  input  wire logic signed [DELTA_W-1:0]  log_scale_x_i,
  input  wire logic signed [DELTA_W-1:0]  log_scale_y_i,
  input  wire logic signed [DELTA_W-1:0]  log_scale_z_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [BOX_W-1:0]                box_x_lo_o,
  output logic [BOX_W-1:0]                box_y_lo_o,
  output logic [BOX_W-1:0]                box_z_lo_o,
  output logic [BOX_W-1:0]                box_x_hi_o,
  output logic [BOX_W-1:0]                box_y_hi_o,
  output logic [BOX_W-1:0]                box_z_hi_o,
  output logic                            keep_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i
);

  // Configuration registers; a write to an unused index is dropped.
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [BOX_W-1:0]  min_size_q;
  logic [GAIN_W-1:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q   <= SIZE_RESET;
      size_y_q   <= SIZE_RESET;
      size_z_q   <= SIZE_RESET;
      min_size_q <= MIN_RESET;
      gain_q     <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SIZE_X:   size_x_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y:   size_y_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z:   size_z_q   <= cfg_data_i[SIZE_W-1:0];
        REG_MIN_SIZE: min_size_q <= cfg_data_i;
        REG_GAIN:     gain_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage ready; a stage loads when empty or draining.
  logic [5:1] vld_q;
  logic [5:1] rdy_w;
  abd3_stage_en_t en_w;

  always_comb begin
    rdy_w[5] = !vld_q[5] || !out_stall_i;
    rdy_w[4] = !vld_q[4] || rdy_w[5];
    rdy_w[3] = !vld_q[3] || rdy_w[4];
    rdy_w[2] = !vld_q[2] || rdy_w[3];
    rdy_w[1] = !vld_q[1] || rdy_w[2];
    en_w.s1  = rdy_w[1];
    en_w.s2  = rdy_w[2];
    en_w.s3  = rdy_w[3];
    en_w.s4  = rdy_w[4];
  end

  assign in_stall_o = !rdy_w[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy_w[1]) vld_q[1] <= in_valid_i;
      if (rdy_w[2]) vld_q[2] <= vld_q[1];
      if (rdy_w[3]) vld_q[3] <= vld_q[2];
      if (rdy_w[4]) vld_q[4] <= vld_q[3];
      if (rdy_w[5]) vld_q[5] <= vld_q[4];
    end
  end

  // One datapath per axis.
  logic [BOX_W-1:0] lo_w [3];
  logic [BOX_W-1:0] hi_w [3];
  logic [2:0]       ins_w;

  abd3_axis #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_axis_x (
    .clk_i      (clk_i),
    .en_i       (en_w),
    .anchor_lo_i(anchor_x_lo_i),
    .anchor_hi_i(anchor_x_hi_i),
    .shift_i    (shift_x_i),
    .log_scale_i(log_scale_x_i),
    .gain_i     (gain_q),
    .size_i     (size_x_q),
    .box_lo_o   (lo_w[0]),
    .box_hi_o   (hi_w[0]),
    .inside_o   (ins_w[0])
  );

  abd3_axis #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_axis_y (
    .clk_i      (clk_i),
    .en_i       (en_w),
    .anchor_lo_i(anchor_y_lo_i),
    .anchor_hi_i(anchor_y_hi_i),
    .shift_i    (shift_y_i),
    .log_scale_i(log_scale_y_i),
    .gain_i     (gain_q),
    .size_i     (size_y_q),
    .box_lo_o   (lo_w[1]),
    .box_hi_o   (hi_w[1]),
    .inside_o   (ins_w[1])
  );

  abd3_axis #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_axis_z (
    .clk_i      (clk_i),
    .en_i       (en_w),
    .anchor_lo_i(anchor_z_lo_i),
    .anchor_hi_i(anchor_z_hi_i),
    .shift_i    (shift_z_i),
    .log_scale_i(log_scale_z_i),
    .gain_i     (gain_q),
    .size_i     (size_z_q),
    .box_lo_o   (lo_w[2]),
    .box_hi_o   (hi_w[2]),
    .inside_o   (ins_w[2])
  );

  // Output stage: extent test on the clipped corners and the keep flag.
  logic [2:0]         big_w;
  logic signed [17:0] span_w [3];
  logic               keep_d, keep_q;
  logic [BOX_W-1:0]   lo_q [3];
  logic [BOX_W-1:0]   hi_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      span_w[a] = $signed({2'b0, hi_w[a]}) - $signed({2'b0, lo_w[a]}) + 18'sd16;
      big_w[a]  = span_w[a] >= $signed({2'b0, min_size_q});
    end
    keep_d = (&ins_w) && (&big_w);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_w[5]) begin
      lo_q   <= lo_w;
      hi_q   <= hi_w;
      keep_q <= keep_d;
    end
  end

  assign out_valid_o = vld_q[5];
  assign box_x_lo_o  = lo_q[0];
  assign box_y_lo_o  = lo_q[1];
  assign box_z_lo_o  = lo_q[2];
  assign box_x_hi_o  = hi_q[0];
  assign box_y_hi_o  = hi_q[1];
  assign box_z_hi_o  = hi_q[2];
  assign keep_o      = keep_q;

endmodule

`default_nettype wire

[tb/sv/anchor_box_delta_decoder_3d_top_test.sv]
// Self-checking testbench of the 3D anchor box delta decoder top level.
// It predicts each output beat, compares them in order and drives random idling on
// both channels; it depends on abd3_pkg and anchor_box_delta_decoder_3d_top.
`default_nettype none

module anchor_box_delta_decoder_3d_top_test;
  import abd3_pkg::*;

  localparam int unsigned TBL_DEPTH = ABD3_EXP_TABLE_DEPTH;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct {
    logic signed [ANCHOR_W-1:0] lo[3];
    logic signed [ANCHOR_W-1:0] hi[3];
    logic signed [DELTA_W-1:0]  shift[3];
    logic signed [DELTA_W-1:0]  log_scale[3];
  } anchor_t;

  typedef struct {
    logic [BOX_W-1:0] lo[3];
    logic [BOX_W-1:0] hi[3];
    logic             keep;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [ANCHOR_W-1:0] anchor_x_lo_i = '0, anchor_y_lo_i = '0, anchor_z_lo_i = '0;
  logic signed [ANCHOR_W-1:0] anchor_x_hi_i = '0, anchor_y_hi_i = '0, anchor_z_hi_i = '0;
  logic signed [DELTA_W-1:0] shift_x_i = '0, shift_y_i = '0, shift_z_i = '0;
  logic signed [DELTA_W-1:0] log_scale_x_i = '0, log_scale_y_i = '0, log_scale_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [BOX_W-1:0] box_x_lo_o, box_y_lo_o, box_z_lo_o, box_x_hi_o, box_y_hi_o, box_z_hi_o;
  logic keep_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  anchor_box_delta_decoder_3d_top dut (.*);

  // Configuration as the block should hold it.
  longint unsigned img_size[3];
  longint unsigned min_extent;
  longint unsigned size_gain;
  longint unsigned pow2_frac[TBL_DEPTH];

  box_t expected_boxes[$];
  int   error_count = 0;
  int   beats_sent = 0;
  int   beats_checked = 0;
  int   kept_count = 0;
  bit   idling_on = 1'b1;

  // Clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #(20 * 600000);
    $display("anchor_box_delta_decoder_3d_top: mismatch");
    $finish;
  end

  // Table of 2^(i/depth) in Q1.30 from a truncated integer Taylor series.
  function automatic void build_pow2_table();
    longint unsigned arg, term, acc;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      arg  = (longint'(i) * 64'd744261118) / TBL_DEPTH;
      term = 64'd1 << 30;
      acc  = term;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * arg) >> 30) / k;
        acc  = acc + term;
      end
      pow2_frac[i] = acc;
    end
  endfunction

  // Clip a Q.4 coordinate to the image along one axis.
  function automatic longint clamp_to_image(longint v, longint unsigned size);
    longint lim;
    lim = (size >= 1) ? (longint'(size) - 1) * 16 : 0;
    if (lim > 65535) lim = 65535;
    if (v > lim) v = lim;
    if (v < 0) v = 0;
    return v;
  endfunction

  // Decode one axis; returns whether the anchor lies inside the image along it.
  function automatic bit decode_one_axis(input logic signed [ANCHOR_W-1:0] lo_c,
                                         input logic signed [ANCHOR_W-1:0] hi_c,
                                         input logic signed [DELTA_W-1:0] sh,
                                         input logic signed [DELTA_W-1:0] ls,
                                         input longint unsigned size,
                                         output longint q_lo, output longint q_hi);
    longint lo, hi, ext, ctr, x, pw, half, sft;
    longint unsigned y, rem, mant, mag, prod, idx;
    lo  = lo_c;
    hi  = hi_c;
    ext = hi - lo + 1;
    ctr = lo * 16 + ext * 8;
    ctr = ctr + ((longint'(sh) * ext + 128) >>> 8);
    // Exponent split into a power of two and a table fraction.
    x = ls;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    if (x >= 0) begin
      y   = longint'(x) * 64'd1549082005;
      pw  = y >> 42;
      rem = y & ((64'd1 << 42) - 1);
    end else begin
      y   = longint'(-x) * 64'd1549082005;
      pw  = -longint'(y >> 42);
      rem = y & ((64'd1 << 42) - 1);
      if (rem != 0) begin
        pw  = pw - 1;
        rem = (64'd1 << 42) - rem;
      end
    end
    idx = (rem * TBL_DEPTH) >> 42;
    if (idx >= TBL_DEPTH) idx = TBL_DEPTH - 1;
    mant = pow2_frac[idx];
    mag  = (ext < 0) ? -ext : ext;
    prod = mant * mag * size_gain;
    sft  = 39 - pw;
    if (sft > 62) half = 0;
    else half = (prod + (64'd1 << (sft - 1))) >> sft;
    if (ext < 0) half = -half;
    q_lo = clamp_to_image(ctr - half, size);
    q_hi = clamp_to_image(ctr + half, size);
    return (lo >= 0) && (hi < longint'(size));
  endfunction

  // Expected output beat of one anchor under the current configuration.
  function automatic box_t predict_box(anchor_t a);
    box_t   r;
    longint q_lo, q_hi;
    r.keep = 1'b1;
    for (int ax = 0; ax < 3; ax++) begin
      if (!decode_one_axis(a.lo[ax], a.hi[ax], a.shift[ax], a.log_scale[ax],
                           img_size[ax], q_lo, q_hi))
        r.keep = 1'b0;
      if (q_hi - q_lo + 16 < longint'(min_extent)) r.keep = 1'b0;
      r.lo[ax] = q_lo[15:0];
      r.hi[ax] = q_hi[15:0];
    end
    return r;
  endfunction

  // Append one prediction at the back of the expected queue.
  function automatic void append_expected(box_t b);
    expected_boxes.insert(expected_boxes.size(), b);
  endfunction

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int p;
    if (!idling_on) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // Output stall pattern in bursts.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= (idle_len() > 0);
      stall_left  <= idle_len();
    end
  end

  // Input monitor: predict each accepted beat.
  always @(posedge clk_i) begin
    anchor_t a;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      a.lo = '{anchor_x_lo_i, anchor_y_lo_i, anchor_z_lo_i};
      a.hi = '{anchor_x_hi_i, anchor_y_hi_i, anchor_z_hi_i};
      a.shift = '{shift_x_i, shift_y_i, shift_z_i};
      a.log_scale = '{log_scale_x_i, log_scale_y_i, log_scale_z_i};
      append_expected(predict_box(a));
      beats_sent++;
    end
  end

  // Output checker: compare each accepted beat with the oldest prediction.
  always @(posedge clk_i) begin
    box_t e;
    box_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.lo = '{box_x_lo_o, box_y_lo_o, box_z_lo_o};
      got.hi = '{box_x_hi_o, box_y_hi_o, box_z_hi_o};
      got.keep = keep_o;
      if (expected_boxes.size() == 0) begin
        $display("%0t: output beat with nothing expected", $time);
        error_count++;
      end else begin
        e = expected_boxes.pop_front();
        beats_checked++;
        if (e.keep) kept_count++;
        for (int ax = 0; ax < 3; ax++) begin
          if (got.lo[ax] !== e.lo[ax]) begin
            $display("%0t: axis %0d lo expected %0d actual %0d", $time, ax, e.lo[ax],
                     got.lo[ax]);
            error_count++;
          end
          if (got.hi[ax] !== e.hi[ax]) begin
            $display("%0t: axis %0d hi expected %0d actual %0d", $time, ax, e.hi[ax],
                     got.hi[ax]);
            error_count++;
          end
        end
        if (got.keep !== e.keep) begin
          $display("%0t: keep expected %0b actual %0b", $time, e.keep, got.keep);
          error_count++;
        end
      end
    end
  end

  // Send one anchor beat, after a random gap.
  task automatic send_anchor(anchor_t a);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    {anchor_x_lo_i, anchor_y_lo_i, anchor_z_lo_i} <= {a.lo[0], a.lo[1], a.lo[2]};
    {anchor_x_hi_i, anchor_y_hi_i, anchor_z_hi_i} <= {a.hi[0], a.hi[1], a.hi[2]};
    {shift_x_i, shift_y_i, shift_z_i} <= {a.shift[0], a.shift[1], a.shift[2]};
    {log_scale_x_i, log_scale_y_i, log_scale_z_i} <=
      {a.log_scale[0], a.log_scale[1], a.log_scale[2]};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every expected beat has come back and the pipe has emptied.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SIZE_X:   img_size[0] = 64'(data & 16'h1FFF);
      REG_SIZE_Y:   img_size[1] = 64'(data & 16'h1FFF);
      REG_SIZE_Z:   img_size[2] = 64'(data & 16'h1FFF);
      REG_MIN_SIZE: min_extent  = 64'(data);
      REG_GAIN:     size_gain   = 64'(data);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                            logic [15:0] mn, logic [15:0] gn);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_MIN_SIZE, mn);
    write_reg(REG_GAIN, gn);
  endtask

  // Random anchor: mostly plausible boxes, sometimes whole-range noise.
  function automatic anchor_t random_anchor();
    anchor_t a;
    int p, lo, len;
    for (int ax = 0; ax < 3; ax++) begin
      p = $urandom_range(99);
      if (p < 75) begin
        lo  = $urandom_range(32'(img_size[ax] + 20)) - 20;
        len = $urandom_range(100) - 4;
        a.lo[ax] = ANCHOR_W'(lo);
        a.hi[ax] = ANCHOR_W'(lo + len);
        a.shift[ax] = DELTA_W'($urandom_range(2400) - 1200);
        a.log_scale[ax] = DELTA_W'($urandom_range(8000) - 4000);
      end else begin
        a.lo[ax] = ANCHOR_W'($urandom);
        a.hi[ax] = ANCHOR_W'($urandom);
        a.shift[ax] = DELTA_W'($urandom);
        a.log_scale[ax] = DELTA_W'($urandom);
      end
    end
    return a;
  endfunction

  function automatic anchor_t make_anchor(int lo, int hi, int sh, int ls);
    anchor_t a;
    for (int ax = 0; ax < 3; ax++) begin
      a.lo[ax] = ANCHOR_W'(lo);
      a.hi[ax] = ANCHOR_W'(hi);
      a.shift[ax] = DELTA_W'(sh);
      a.log_scale[ax] = DELTA_W'(ls);
    end
    return a;
  endfunction

  // Directed beats under the reset configuration.
  task automatic test_reset_defaults();
    send_anchor(make_anchor(10, 25, 0, 0));
    send_anchor(make_anchor(0, 4095, 0, 0));
    send_anchor(make_anchor(-8192, 8191, 0, 0));
    send_anchor(make_anchor(8191, -8192, 0, 0));
    send_anchor(make_anchor(30, 20, 4096, 2000));
    send_anchor(make_anchor(40, 39, 100, 100));
    send_anchor(make_anchor(100, 140, 32767, 32767));
    send_anchor(make_anchor(100, 140, -32768, -32768));
    send_anchor(make_anchor(100, 140, 2048, 32000));
    send_anchor(make_anchor(100, 140, -2048, -32000));
    send_anchor(make_anchor(-5, 3, -1, -1));
    send_anchor(make_anchor(4090, 4096, 1, 1));
    send_anchor(make_anchor(200, 200, 128, -4096));
    drain();
  endtask

  // Directed beats at configuration extremes, then writes to unused indexes.
  task automatic test_config_extremes();
    set_config(16'd1, 16'd0, 16'h1FFF, 16'hFFFF, 16'hFFFF);
    send_anchor(make_anchor(0, 0, 0, 0));
    send_anchor(make_anchor(0, 3, 0, 32767));
    send_anchor(make_anchor(-1, 8000, 500, 3000));
    drain();
    set_config(16'hE000 | 16'd64, 16'd4096, 16'd7, 16'd0, 16'd0);
    send_anchor(make_anchor(2, 5, 0, 0));
    send_anchor(make_anchor(0, 63, -300, 8000));
    drain();
    write_reg(REG_UNUSED_LO, 16'h0003);
    write_reg(REG_UNUSED_HI, 16'hFFFF);
    send_anchor(make_anchor(1, 4, 0, 0));
    drain();
  endtask

  // Random beats under one configuration.
  task automatic test_random_phase(int count);
    repeat (count) send_anchor(random_anchor());
    drain();
  endtask

  initial begin
    img_size = '{4096, 4096, 4096};
    min_extent = 0;
    size_gain = 4096;
    build_pow2_table();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    set_config(16'd4096, 16'd4096, 16'd4096, 16'd0, 16'd4096);
    test_random_phase(150);
    set_config(16'd128, 16'd96, 16'd200, 16'd320, 16'd6144);
    test_random_phase(150);
    idling_on = 1'b0;
    set_config(16'd1, 16'd4096, 16'd50, 16'hFFFF, 16'hFFFF);
    test_random_phase(100);
    idling_on = 1'b1;
    set_config(16'd300, 16'd0, 16'h1FFF, 16'd16, 16'd0);
    test_random_phase(150);
    set_config(16'($urandom_range(4096, 1)), 16'($urandom_range(4096, 1)),
               16'($urandom_range(4096, 1)), 16'($urandom_range(800)),
               16'($urandom_range(65535)));
    test_random_phase(180);

    $display("Checked %0d of %0d anchor beats (%0d kept) over eight register settings.",
             beats_checked, beats_sent, kept_count);
    if (error_count == 0 && expected_boxes.size() == 0) begin
      $display("anchor_box_delta_decoder_3d_top: match");
    end else begin
      $display("anchor_box_delta_decoder_3d_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/abd3_pkg.sv
hdl/abd3_exp_rom.sv
hdl/abd3_axis.sv
hdl/anchor_box_delta_decoder_3d_top.sv
tb/sv/anchor_box_delta_decoder_3d_top_test.sv
